// File: design/stick_adc_to_pulse_width_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the stick ADC to pulse width converter
// Concurrent assertion wrappers clocked on clk_i; removable with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef STICK_ADC_TO_PULSE_WIDTH_CORE_ASSERT_SVH
`define STICK_ADC_TO_PULSE_WIDTH_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked only while reset is released.
`define SAPW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every edge, reset included.
`define SAPW_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SAPW_ASSERT(name, prop, msg)
`define SAPW_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// File: design/sapw_pkg.sv
// ---------------------------------------------------------------------------
// sapw_pkg
// Shared widths, constants, register indexes and control types.
// ---------------------------------------------------------------------------
package sapw_pkg;

  localparam int NumCh  = 4;
  localparam int AdcW   = 12;
  localparam int SumW   = 14;
  localparam int PulseW = 11;
  localparam int PhaseW = 3;
  localparam int ProdW  = 22;
  localparam int QuotW  = 10;

  localparam logic [PhaseW-1:0] PhaseFirst = 3'd1;
  localparam logic [PhaseW-1:0] PhaseLast  = 3'd5;

  localparam logic [PulseW-1:0] PulseMin  = 11'd1000;
  localparam logic [PulseW-1:0] PulseMax  = 11'd2000;
  localparam logic [ProdW-1:0]  Span      = 22'd1000;
  localparam logic [ProdW-1:0]  FullScale = 22'd4095;
  localparam logic [SumW-1:0]   Centre    = 14'd2048;

  localparam logic [AdcW-1:0] OffsetRst [NumCh] = '{12'd2048, 12'd2048, 12'd0, 12'd2048};

  typedef enum logic [1:0] {
    CFG_OFFSET_CH1 = 2'd0,
    CFG_OFFSET_CH2 = 2'd1,
    CFG_OFFSET_CH3 = 2'd2,
    CFG_OFFSET_CH4 = 2'd3
  } cfg_idx_e;

  // Pipeline advance controls shared by all lanes.
  typedef struct packed {
    logic load;  // capture the finished sums into stage one
    logic adv;   // move stage one into stage two
  } sapw_ctrl_t;

endpackage

// File: design/stick_adc_to_pulse_width_core.sv
// ---------------------------------------------------------------------------
// stick_adc_to_pulse_width_core
// Four stick ADC channels averaged over four scans and mapped to servo pulses.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i / in_ready_o) carries one item per scan with
// four 12-bit samples. Items run in cycles of five: the first four are summed
// per channel, the fifth is only a trigger and its samples are dropped. On the
// fifth item each average is offset, scaled to 1000..2000 us and clamped, and
// one result item leaves on the output channel (out_valid_o / out_ready_i).
// Throughput is one input item per clock unless a trigger item is held back;
// accumulation items never wait. After its trigger item is accepted, a result
// moves from stage one (the sums) through stage two (the scaled product) into
// the output register, where it is shown and can be taken.
// When the receiver stalls, the result waits in the output register and the
// two stages behind it fill; a trigger item is held back only when stage one
// cannot move. Accumulation continues meanwhile. The user writes the offset
// registers through cfg_we_i / cfg_idx_i / cfg_wdata_i only while the block
// is idle, which the block does not enforce. Reset clears the sums, restarts
// the cycle at its first item, empties the pipeline and loads default offsets.
// ---------------------------------------------------------------------------
`include "stick_adc_to_pulse_width_core_assert.svh"

module stick_adc_to_pulse_width_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [sapw_pkg::AdcW-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [sapw_pkg::AdcW-1:0]           adc_ch1_i,
  input  logic [sapw_pkg::AdcW-1:0]           adc_ch2_i,
  input  logic [sapw_pkg::AdcW-1:0]           adc_ch3_i,
  input  logic [sapw_pkg::AdcW-1:0]           adc_ch4_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sapw_pkg::PulseW-1:0]         pulse_ch1_o,
  output logic [sapw_pkg::PulseW-1:0]         pulse_ch2_o,
  output logic [sapw_pkg::PulseW-1:0]         pulse_ch3_o,
  output logic [sapw_pkg::PulseW-1:0]         pulse_ch4_o
);

  logic [sapw_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [sapw_pkg::SumW-1:0]   sums_q [sapw_pkg::NumCh];
  logic [sapw_pkg::SumW-1:0]   sums_d [sapw_pkg::NumCh];
  logic [sapw_pkg::AdcW-1:0]   offs_q [sapw_pkg::NumCh];
  logic [sapw_pkg::AdcW-1:0]   adc    [sapw_pkg::NumCh];
  logic [sapw_pkg::PulseW-1:0] lane_pulse [sapw_pkg::NumCh];
  logic [sapw_pkg::PulseW-1:0] pulse_q    [sapw_pkg::NumCh];

  logic s1_v_q, s1_v_d, s2_v_q, s2_v_d, out_v_q, out_v_d;
  logic in_fire, out_fire, trigger;
  logic out_free, s2_free, s1_free, s1_go, s2_go;

  sapw_pkg::sapw_ctrl_t ctrl;

  assign adc[0] = adc_ch1_i;
  assign adc[1] = adc_ch2_i;
  assign adc[2] = adc_ch3_i;
  assign adc[3] = adc_ch4_i;

  // Ready chain from the output register back to stage one.
  assign out_free = !out_v_q || out_ready_i;
  assign s2_go    = s2_v_q && out_free;
  assign s2_free  = !s2_v_q || out_free;
  assign s1_go    = s1_v_q && s2_free;
  assign s1_free  = !s1_v_q || s2_free;

  // Only the trigger item needs room in the pipeline.
  assign in_ready_o = (phase_q != sapw_pkg::PhaseLast) || s1_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign trigger    = in_fire && (phase_q == sapw_pkg::PhaseLast);
  assign out_fire   = out_v_q && out_ready_i;

  assign ctrl.load = trigger;
  assign ctrl.adv  = s1_go;

  // Accumulators and the position in the five-item cycle.
  always_comb begin
    phase_d = phase_q;
    for (int i = 0; i < sapw_pkg::NumCh; i++) begin
      sums_d[i] = sums_q[i];
    end
    if (trigger) begin
      phase_d = sapw_pkg::PhaseFirst;
      for (int i = 0; i < sapw_pkg::NumCh; i++) begin
        sums_d[i] = '0;
      end
    end else if (in_fire) begin
      phase_d = phase_q + 1'b1;
      for (int i = 0; i < sapw_pkg::NumCh; i++) begin
        sums_d[i] = sums_q[i] + sapw_pkg::SumW'(adc[i]);
      end
    end
  end

  always_comb begin
    s1_v_d  = trigger ? 1'b1 : (s1_go ? 1'b0 : s1_v_q);
    s2_v_d  = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_v_q);
    out_v_d = s2_go ? 1'b1 : (out_fire ? 1'b0 : out_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sapw_pkg::PhaseFirst;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i < sapw_pkg::NumCh; i++) begin
        sums_q[i] <= '0;
      end
    end else begin
      phase_q <= phase_d;
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s2_v_d;
      out_v_q <= out_v_d;
      for (int i = 0; i < sapw_pkg::NumCh; i++) begin
        sums_q[i] <= sums_d[i];
      end
    end
  end

  // Offset registers; every index of the port names a register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sapw_pkg::NumCh; i++) begin
        offs_q[i] <= sapw_pkg::OffsetRst[i];
      end
    end else if (cfg_we_i) begin
      case (sapw_pkg::cfg_idx_e'(cfg_idx_i))
        sapw_pkg::CFG_OFFSET_CH1: offs_q[0] <= cfg_wdata_i;
        sapw_pkg::CFG_OFFSET_CH2: offs_q[1] <= cfg_wdata_i;
        sapw_pkg::CFG_OFFSET_CH3: offs_q[2] <= cfg_wdata_i;
        sapw_pkg::CFG_OFFSET_CH4: offs_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // One lane per channel. The throttle lane has no centring term.
  for (genvar g = 0; g < sapw_pkg::NumCh; g++) begin : g_lane
    sapw_lane u_lane (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .centered_i (g != 2),
      .sum_i      (sums_q[g]),
      .offset_i   (offs_q[g]),
      .pulse_o    (lane_pulse[g])
    );
  end

  // Merge: all four lanes land in the output register together.
  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      for (int i = 0; i < sapw_pkg::NumCh; i++) begin
        pulse_q[i] <= lane_pulse[i];
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign pulse_ch1_o = pulse_q[0];
  assign pulse_ch2_o = pulse_q[1];
  assign pulse_ch3_o = pulse_q[2];
  assign pulse_ch4_o = pulse_q[3];

  `SAPW_ASSERT_ALWAYS(a_reset_state, !rst_ni |=> (phase_q == sapw_pkg::PhaseFirst && !out_v_q), "reset did not restart the cycle")
  `SAPW_ASSERT(a_phase_range, (phase_q >= sapw_pkg::PhaseFirst && phase_q <= sapw_pkg::PhaseLast), "cycle position out of range")
  `SAPW_ASSERT(a_trigger_clears, trigger |=> (phase_q == sapw_pkg::PhaseFirst && sums_q[0] == '0 && sums_q[3] == '0), "trigger did not clear the accumulators")
  `SAPW_ASSERT(a_trigger_loads, trigger |=> s1_v_q, "trigger item did not enter the pipeline")
  `SAPW_ASSERT(a_pulse_range, out_v_q |-> (pulse_q[0] >= sapw_pkg::PulseMin && pulse_q[0] <= sapw_pkg::PulseMax && pulse_q[2] >= sapw_pkg::PulseMin && pulse_q[2] <= sapw_pkg::PulseMax), "pulse outside clamp range")

endmodule

// File: design/sapw_lane.sv
// ---------------------------------------------------------------------------
// sapw_lane
// One channel: average, offset removal, scaling by 1000/4095 and clamping.
// ---------------------------------------------------------------------------
module sapw_lane (
  input  logic                           clk_i,
  input  sapw_pkg::sapw_ctrl_t           ctrl_i,
  input  logic                           centered_i,
  input  logic [sapw_pkg::SumW-1:0]      sum_i,
  input  logic [sapw_pkg::AdcW-1:0]      offset_i,
  output logic [sapw_pkg::PulseW-1:0]    pulse_o
);

  logic [sapw_pkg::SumW-1:0]   sum_q;
  logic signed [sapw_pkg::SumW-1:0] diff;
  logic                        sat_lo_d, sat_hi_d, sat_lo_q, sat_hi_q;
  logic [sapw_pkg::ProdW-1:0]  prod_d, prod_q;
  logic [sapw_pkg::QuotW-1:0]  quot_est, quot;
  logic [sapw_pkg::ProdW-1:0]  quot_x, rem;

  // Stage one: the sum of the cycle, held until stage two is free.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sum_q <= sum_i;
    end
  end

  // Signed difference from the rest position; a value at or below zero ends
  // at the lower clamp, and one of 4095 or more at the upper clamp.
  assign diff = $signed({2'b00, sum_q[sapw_pkg::SumW-1:2]})
              - $signed({2'b00, offset_i})
              + $signed(centered_i ? sapw_pkg::Centre : '0);
  assign sat_lo_d = diff[sapw_pkg::SumW-1];
  assign sat_hi_d = !sat_lo_d && (diff >= $signed(sapw_pkg::SumW'(sapw_pkg::FullScale)));
  assign prod_d   = sapw_pkg::ProdW'(diff[sapw_pkg::AdcW-1:0]) * sapw_pkg::Span;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      prod_q   <= prod_d;
      sat_lo_q <= sat_lo_d;
      sat_hi_q <= sat_hi_d;
    end
  end

  // Stage two: divide by 4095. The shift by 12 is low by at most one, and one
  // compare of the remainder settles it.
  assign quot_est = prod_q[sapw_pkg::ProdW-1:12];
  assign quot_x   = {quot_est, 12'b0} - sapw_pkg::ProdW'(quot_est);
  assign rem      = prod_q - quot_x;
  assign quot     = (rem >= sapw_pkg::FullScale) ? quot_est + 1'b1 : quot_est;

  always_comb begin
    if (sat_hi_q) begin
      pulse_o = sapw_pkg::PulseMax;
    end else if (sat_lo_q) begin
      pulse_o = sapw_pkg::PulseMin;
    end else begin
      pulse_o = sapw_pkg::PulseMin + sapw_pkg::PulseW'(quot);
    end
  end

endmodule
